// File: rtl/core/occupancy_grid_rect_fill_macros.svh
// ----------------------------------------------------------------------------
// occupancy grid rectangle fill: assertion macros
// shared property forms clocked on clock and masked during reset
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_RECT_FILL_MACROS_SVH
`define OCCUPANCY_GRID_RECT_FILL_MACROS_SVH

// same-cycle implication
`define OGRF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OGRF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ogrf_pkg.sv
// ----------------------------------------------------------------------------
// ogrf_pkg
// sizes, codes, interface structs and helpers of the occupancy grid fill block
// ----------------------------------------------------------------------------
package ogrf_pkg;

   localparam int GRID_SIDE_MAX  = 1024;
   localparam int CELL_BITS      = $clog2(GRID_SIDE_MAX);
   localparam int SIDE_BITS      = $clog2(GRID_SIDE_MAX + 1);
   localparam int SIDE_MIN       = 3;

   localparam int WORD_BITS      = 64;
   localparam int WORD_OFS_BITS  = 6;
   localparam int Y_PAD_BITS     = (CELL_BITS > WORD_OFS_BITS) ? CELL_BITS : WORD_OFS_BITS + 1;
   localparam int WSEL_BITS      = Y_PAD_BITS - WORD_OFS_BITS;
   localparam int WORDS_PER_ROW  = 2 ** WSEL_BITS;
   localparam int MEM_DEPTH      = GRID_SIDE_MAX * WORDS_PER_ROW;
   localparam int ADDR_BITS      = CELL_BITS + WSEL_BITS;

   localparam int COORD_BITS     = 16;
   localparam int MAP_SIZE_BITS  = 11;
   localparam logic [MAP_SIZE_BITS-1:0] MAP_SIZE_RESET = MAP_SIZE_BITS'(1000);

   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic REG_MAP_SIZE = 1'b0;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_READ   = 2'd1,
      OP_REINIT = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // one word of a row selected for masking
   typedef struct packed {
      logic                  ends_only;
      logic [WSEL_BITS-1:0]  word;
      logic [Y_PAD_BITS-1:0] lo;
      logic [Y_PAD_BITS-1:0] hi;
   } span_req_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0] mask;
      logic [WORD_BITS-1:0] data;
   } mem_wr_type;

   function automatic logic [SIDE_BITS-1:0] side_in_use(
      input logic [MAP_SIZE_BITS-1:0] map_size
   );
      logic [31:0] wide;
      wide = 32'(map_size);
      if (wide < 32'(SIDE_MIN)) begin
         return SIDE_BITS'(SIDE_MIN);
      end else if (wide > 32'(GRID_SIDE_MAX)) begin
         return SIDE_BITS'(GRID_SIDE_MAX);
      end
      return SIDE_BITS'(wide);
   endfunction

   function automatic logic [WSEL_BITS-1:0] word_of(input logic [CELL_BITS-1:0] y);
      logic [Y_PAD_BITS-1:0] pad;
      pad = Y_PAD_BITS'(y);
      return pad[Y_PAD_BITS-1:WORD_OFS_BITS];
   endfunction

   function automatic logic [WORD_OFS_BITS-1:0] bit_of(input logic [CELL_BITS-1:0] y);
      logic [Y_PAD_BITS-1:0] pad;
      pad = Y_PAD_BITS'(y);
      return pad[WORD_OFS_BITS-1:0];
   endfunction

endpackage

// File: rtl/core/occupancy_grid_rect_fill.sv
// ----------------------------------------------------------------------------
// occupancy_grid_rect_fill
// square obstacle bitmap with fenced border, rectangle fill and cell read
// ----------------------------------------------------------------------------
//  channel  | ports                              | beat
//  ---------+------------------------------------+-----------------------------
//  request  | req_valid/req_stall, op, corners   | one command
//  response | rsp_valid/rsp_stall, occupied/done | one result per command
//  csr      | csr_psel..csr_pready (apb)         | map_size at byte address 0
//
//  add: clamp of all four coordinates, ordering, then a masked write to each 64-bit
//  row word of the rectangle (rows x words spanned), then the output register; read:
//  clamp of corner a, bitmap read, bit select, output register; unused op: output
//  register; reinitialize and map_size write: clearing pass of MEM_DEPTH (16384)
//  words through the single write port, one word per cycle; the same pass runs after
//  reset; the block takes a new command while a result waits under rsp_stall
// ----------------------------------------------------------------------------
`include "occupancy_grid_rect_fill_macros.svh"

module occupancy_grid_rect_fill (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_op,
   input  logic signed [ogrf_pkg::COORD_BITS-1:0]   req_corner_a_x,
   input  logic signed [ogrf_pkg::COORD_BITS-1:0]   req_corner_a_y,
   input  logic signed [ogrf_pkg::COORD_BITS-1:0]   req_corner_b_x,
   input  logic signed [ogrf_pkg::COORD_BITS-1:0]   req_corner_b_y,

   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_occupied,
   output logic                                     rsp_done_res,

   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [ogrf_pkg::CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [ogrf_pkg::CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic [ogrf_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                     csr_pready
);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_CLAMP,
      ST_ORDER,
      ST_FILL,
      ST_READ,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

   state_type                              state_ff;
   logic [ogrf_pkg::MAP_SIZE_BITS-1:0]     map_size_ff;
   ogrf_pkg::op_type                       op_ff;
   logic signed [ogrf_pkg::COORD_BITS-1:0] coord_ff [4];
   logic [1:0]                             step_ff;
   logic [ogrf_pkg::CELL_BITS-1:0]         cx_ff [4];
   logic                                   oob_ff;
   logic [ogrf_pkg::CELL_BITS-1:0]         x_lo_ff;
   logic [ogrf_pkg::CELL_BITS-1:0]         x_hi_ff;
   logic [ogrf_pkg::CELL_BITS-1:0]         y_lo_ff;
   logic [ogrf_pkg::CELL_BITS-1:0]         y_hi_ff;
   logic [ogrf_pkg::CELL_BITS-1:0]         cur_x_ff;
   logic [ogrf_pkg::WSEL_BITS-1:0]         cur_w_ff;
   logic [ogrf_pkg::ADDR_BITS-1:0]         sweep_addr_ff;
   logic                                   item_sweep_ff;
   logic                                   occ_ff;
   logic                                   rsp_valid_ff;
   logic                                   rsp_occupied_ff;
   logic                                   rsp_done_res_ff;

   logic [ogrf_pkg::SIDE_BITS-1:0]         side;
   logic [ogrf_pkg::CELL_BITS-1:0]         side_last;
   logic                                   req_accept;
   logic                                   csr_write;
   logic                                   map_write;
   logic [ogrf_pkg::CELL_BITS-1:0]         sweep_x;
   logic [ogrf_pkg::CELL_BITS-1:0]         clamped;
   logic                                   below;
   logic                                   above;
   ogrf_pkg::span_req_type                 span_req;
   logic [ogrf_pkg::WORD_BITS-1:0]         span_mask;
   ogrf_pkg::mem_wr_type                   mem_wr;
   logic                                   rd_en;
   logic [ogrf_pkg::ADDR_BITS-1:0]         rd_addr;
   logic [ogrf_pkg::WORD_BITS-1:0]         rd_data;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign map_write  = csr_write && (csr_paddr[2] == ogrf_pkg::REG_MAP_SIZE);
   assign csr_prdata = (csr_paddr[2] == ogrf_pkg::REG_MAP_SIZE) ?
                       ogrf_pkg::CSR_DATA_BITS'(map_size_ff) : '0;

   assign side       = ogrf_pkg::side_in_use(map_size_ff);
   assign side_last  = ogrf_pkg::CELL_BITS'(side - ogrf_pkg::SIDE_BITS'(1));
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign sweep_x    = sweep_addr_ff[ogrf_pkg::ADDR_BITS-1:ogrf_pkg::WSEL_BITS];

   ogrf_clamp u_clamp (
      .value   (coord_ff[step_ff]),
      .side    (side),
      .clamped (clamped),
      .below   (below),
      .above   (above)
   );

   // fence rows take the whole span, inner rows only its two ends
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         span_req.ends_only = !(sweep_x == '0 || sweep_x == side_last);
         span_req.word      = sweep_addr_ff[ogrf_pkg::WSEL_BITS-1:0];
         span_req.lo        = '0;
         span_req.hi        = ogrf_pkg::Y_PAD_BITS'(side_last);
      end else begin
         span_req.ends_only = 1'b0;
         span_req.word      = cur_w_ff;
         span_req.lo        = ogrf_pkg::Y_PAD_BITS'(y_lo_ff);
         span_req.hi        = ogrf_pkg::Y_PAD_BITS'(y_hi_ff);
      end
   end

   ogrf_span_mask u_span (
      .req  (span_req),
      .mask (span_mask)
   );

   always_comb begin
      mem_wr.en   = (state_ff == ST_SWEEP) || (state_ff == ST_FILL);
      if (state_ff == ST_SWEEP) begin
         mem_wr.addr = sweep_addr_ff;
         mem_wr.mask = '1;
         mem_wr.data = span_mask;
      end else begin
         mem_wr.addr = {cur_x_ff, cur_w_ff};
         mem_wr.mask = span_mask;
         mem_wr.data = '1;
      end
   end

   assign rd_en   = (state_ff == ST_READ);
   assign rd_addr = {cx_ff[0], ogrf_pkg::word_of(cx_ff[1])};

   ogrf_bitmap u_bitmap (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         item_sweep_ff <= 1'b0;
         map_size_ff   <= ogrf_pkg::MAP_SIZE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_SWEEP: begin
               if (sweep_addr_ff == ogrf_pkg::ADDR_BITS'(ogrf_pkg::MEM_DEPTH - 1)) begin
                  state_ff <= item_sweep_ff ? ST_FINISH : ST_IDLE;
               end else begin
                  sweep_addr_ff <= sweep_addr_ff + 1'b1;
               end
            end

            ST_IDLE: begin
               if (req_accept) begin
                  op_ff       <= ogrf_pkg::op_type'(req_op);
                  coord_ff[0] <= req_corner_a_x;
                  coord_ff[1] <= req_corner_a_y;
                  coord_ff[2] <= req_corner_b_x;
                  coord_ff[3] <= req_corner_b_y;
                  step_ff     <= '0;
                  oob_ff      <= 1'b0;
                  occ_ff      <= 1'b0;
                  case (ogrf_pkg::op_type'(req_op))
                     ogrf_pkg::OP_ADD, ogrf_pkg::OP_READ: begin
                        state_ff <= ST_CLAMP;
                     end
                     ogrf_pkg::OP_REINIT: begin
                        sweep_addr_ff <= '0;
                        item_sweep_ff <= 1'b1;
                        state_ff      <= ST_SWEEP;
                     end
                     default: begin
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end

            ST_CLAMP: begin
               cx_ff[step_ff] <= clamped;
               oob_ff         <= oob_ff || below || above;
               step_ff        <= step_ff + 1'b1;
               if (op_ff == ogrf_pkg::OP_READ && step_ff == 2'd1) begin
                  state_ff <= ST_READ;
               end else if (step_ff == 2'd3) begin
                  state_ff <= ST_ORDER;
               end
            end

            // swap reversed corners
            ST_ORDER: begin
               x_lo_ff  <= (cx_ff[0] < cx_ff[2]) ? cx_ff[0] : cx_ff[2];
               x_hi_ff  <= (cx_ff[0] < cx_ff[2]) ? cx_ff[2] : cx_ff[0];
               y_lo_ff  <= (cx_ff[1] < cx_ff[3]) ? cx_ff[1] : cx_ff[3];
               y_hi_ff  <= (cx_ff[1] < cx_ff[3]) ? cx_ff[3] : cx_ff[1];
               cur_x_ff <= (cx_ff[0] < cx_ff[2]) ? cx_ff[0] : cx_ff[2];
               cur_w_ff <= ogrf_pkg::word_of((cx_ff[1] < cx_ff[3]) ? cx_ff[1] : cx_ff[3]);
               state_ff <= ST_FILL;
            end

            ST_FILL: begin
               if (cur_w_ff == ogrf_pkg::word_of(y_hi_ff)) begin
                  cur_w_ff <= ogrf_pkg::word_of(y_lo_ff);
                  if (cur_x_ff == x_hi_ff) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     cur_x_ff <= cur_x_ff + 1'b1;
                  end
               end else begin
                  cur_w_ff <= cur_w_ff + 1'b1;
               end
            end

            ST_READ: begin
               state_ff <= ST_READ_WAIT;
            end

            // outside the arena reads as blocked
            ST_READ_WAIT: begin
               occ_ff   <= oob_ff || rd_data[ogrf_pkg::bit_of(cx_ff[1])];
               state_ff <= ST_FINISH;
            end

            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_occupied_ff <= occ_ff;
                  rsp_done_res_ff <= (op_ff != ogrf_pkg::OP_NONE);
                  state_ff        <= ST_IDLE;
               end
            end
         endcase

         // a resize redraws the grid at the new side
         if (map_write) begin
            map_size_ff   <= csr_pwdata[ogrf_pkg::MAP_SIZE_BITS-1:0];
            sweep_addr_ff <= '0;
            item_sweep_ff <= 1'b0;
            state_ff      <= ST_SWEEP;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_occupied = rsp_occupied_ff;
   assign rsp_done_res = rsp_done_res_ff;

   `OGRF_ASSERT_IMP(a_no_rw_clash, mem_wr.en, !rd_en, "bitmap written and read in one cycle")
   `OGRF_ASSERT_IMP(a_fill_ordered, state_ff == ST_FILL, (x_lo_ff <= x_hi_ff) && (y_lo_ff <= y_hi_ff), "fill corners not ordered")
   `OGRF_ASSERT_IMP(a_fill_row_in_box, state_ff == ST_FILL, (cur_x_ff >= x_lo_ff) && (cur_x_ff <= x_hi_ff), "fill row outside rectangle")
   `OGRF_ASSERT_IMP(a_clamped_in_grid, state_ff == ST_ORDER, (cx_ff[0] <= side_last) && (cx_ff[3] <= side_last), "clamped corner outside grid")
   `OGRF_ASSERT_IMP(a_undone_not_occ, rsp_valid_ff && !rsp_done_res_ff, !rsp_occupied_ff, "unused op reports occupied")
   `OGRF_ASSERT_NXT(a_finish_delivers, (state_ff == ST_FINISH) && !rsp_stall && !map_write, rsp_valid_ff && (state_ff == ST_IDLE), "finished result not loaded")

endmodule

// File: rtl/core/ogrf_clamp.sv
// ----------------------------------------------------------------------------
// ogrf_clamp
// shared coordinate unit: clamps one signed coordinate into the grid
// ----------------------------------------------------------------------------
module ogrf_clamp (
   input  logic signed [ogrf_pkg::COORD_BITS-1:0] value,
   input  logic [ogrf_pkg::SIDE_BITS-1:0]         side,
   output logic [ogrf_pkg::CELL_BITS-1:0]         clamped,
   output logic                                   below,
   output logic                                   above
);

   logic signed [31:0] value_wide;
   logic signed [31:0] side_wide;

   assign value_wide = 32'(value);
   assign side_wide  = signed'(32'(side));
   assign below      = value_wide < 0;
   assign above      = value_wide >= side_wide;

   always_comb begin
      if (below || value_wide == 0) begin
         clamped = '0;
      end else if (above) begin
         clamped = ogrf_pkg::CELL_BITS'(side - ogrf_pkg::SIDE_BITS'(1));
      end else begin
         clamped = ogrf_pkg::CELL_BITS'(value_wide);
      end
   end

endmodule

// File: rtl/core/ogrf_span_mask.sv
// ----------------------------------------------------------------------------
// ogrf_span_mask
// per-bit compare of one row word against a column span or its two ends
// ----------------------------------------------------------------------------
module ogrf_span_mask (
   input  ogrf_pkg::span_req_type              req,
   output logic [ogrf_pkg::WORD_BITS-1:0]      mask
);

   for (genvar i = 0; i < ogrf_pkg::WORD_BITS; i++) begin : g_bit
      logic [ogrf_pkg::Y_PAD_BITS-1:0] pos;
      assign pos = {req.word, ogrf_pkg::WORD_OFS_BITS'(i)};
      assign mask[i] = req.ends_only ? (pos == req.lo || pos == req.hi)
                                     : (pos >= req.lo && pos <= req.hi);
   end

endmodule

// File: rtl/core/ogrf_bitmap.sv
// ----------------------------------------------------------------------------
// ogrf_bitmap
// cell bitmap store: one bit-masked write port, one registered read port
// ----------------------------------------------------------------------------
module ogrf_bitmap (
   input  logic                                clock,
   input  ogrf_pkg::mem_wr_type                wr,
   input  logic                                rd_en,
   input  logic [ogrf_pkg::ADDR_BITS-1:0]      rd_addr,
   output logic [ogrf_pkg::WORD_BITS-1:0]      rd_data
);

   logic [ogrf_pkg::WORD_BITS-1:0] bits_mem [ogrf_pkg::MEM_DEPTH];
   logic [ogrf_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int i = 0; i < ogrf_pkg::WORD_BITS; i++) begin
            if (wr.mask[i]) begin
               bits_mem[wr.addr][i] <= wr.data[i];
            end
         end
      end
      if (rd_en) begin
         rd_data_ff <= bits_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: dv/occupancy_grid_rect_fill_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy grid rectangle fill checker
// watches the request, response and csr beats, keeps its own copy of the
// fenced obstacle grid and map size, and compares every response beat with
// the oldest predicted answer
// ----------------------------------------------------------------------------
module occupancy_grid_rect_fill_checker (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic [1:0]                               req_op,
   input  logic signed [ogrf_pkg::COORD_BITS-1:0]   req_corner_a_x,
   input  logic signed [ogrf_pkg::COORD_BITS-1:0]   req_corner_a_y,
   input  logic signed [ogrf_pkg::COORD_BITS-1:0]   req_corner_b_x,
   input  logic signed [ogrf_pkg::COORD_BITS-1:0]   req_corner_b_y,

   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic                                     rsp_occupied,
   input  logic                                     rsp_done_res,

   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [ogrf_pkg::CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [ogrf_pkg::CSR_DATA_BITS-1:0]       csr_pwdata,
   input  logic [ogrf_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   input  logic                                     csr_pready,

   output int                                       mismatch_count,
   output int                                       answers_pending
);

   typedef struct packed {
      logic occupied;
      logic done_res;
   } cell_answer_type;

   // row x holds the cells (x, 0..GRID_SIDE_MAX-1)
   bit [ogrf_pkg::GRID_SIDE_MAX-1:0]    grid_rows [ogrf_pkg::GRID_SIDE_MAX];
   logic [ogrf_pkg::MAP_SIZE_BITS-1:0]  map_size_q;
   cell_answer_type                     pending_answers [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic int grid_side();
      int s;
      s = int'(map_size_q);
      if (s < ogrf_pkg::SIDE_MIN) s = ogrf_pkg::SIDE_MIN;
      if (s > ogrf_pkg::GRID_SIDE_MAX) s = ogrf_pkg::GRID_SIDE_MAX;
      return s;
   endfunction

   function automatic int clamp_to_grid(input int v, input int s);
      if (v <= 0) return 0;
      if (v >= s) return s - 1;
      return v;
   endfunction

   function automatic void redraw_fence();
      int s;
      bit [ogrf_pkg::GRID_SIDE_MAX-1:0] border_row;
      s = grid_side();
      border_row = {ogrf_pkg::GRID_SIDE_MAX{1'b1}} >> (ogrf_pkg::GRID_SIDE_MAX - s);
      for (int r = 0; r < ogrf_pkg::GRID_SIDE_MAX; r++) begin
         grid_rows[r] = '0;
         if (r < s) begin
            grid_rows[r][0] = 1'b1;
            grid_rows[r][s - 1] = 1'b1;
         end
      end
      grid_rows[0] = border_row;
      grid_rows[s - 1] = border_row;
   endfunction

   function automatic void fill_rect(input int ax, input int ay, input int bx, input int by);
      int s, x0, x1, y0, y1, t;
      bit [ogrf_pkg::GRID_SIDE_MAX-1:0] span;
      s = grid_side();
      x0 = clamp_to_grid(ax, s);
      y0 = clamp_to_grid(ay, s);
      x1 = clamp_to_grid(bx, s);
      y1 = clamp_to_grid(by, s);
      if (x0 > x1) begin
         t = x0;
         x0 = x1;
         x1 = t;
      end
      if (y0 > y1) begin
         t = y0;
         y0 = y1;
         y1 = t;
      end
      // inclusive run of ones from y0 to y1
      span = ({ogrf_pkg::GRID_SIDE_MAX{1'b1}} >>
              (ogrf_pkg::GRID_SIDE_MAX - 1 - (y1 - y0))) << y0;
      for (int x = x0; x <= x1; x++) grid_rows[x] |= span;
   endfunction

   function automatic cell_answer_type predict_cell_answer(
      input ogrf_pkg::op_type op,
      input int               ax,
      input int               ay,
      input int               bx,
      input int               by
   );
      cell_answer_type ans;
      int s;
      s = grid_side();
      ans.occupied = 1'b0;
      ans.done_res = 1'b1;
      case (op)
         ogrf_pkg::OP_ADD: fill_rect(ax, ay, bx, by);
         ogrf_pkg::OP_READ: begin
            // anything off the arena reads as blocked
            if (ax < 0 || ay < 0 || ax >= s || ay >= s) ans.occupied = 1'b1;
            else ans.occupied = grid_rows[ax][ay];
         end
         ogrf_pkg::OP_REINIT: redraw_fence();
         default: ans.done_res = 1'b0;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      cell_answer_type want;
      int reg_index;
      reg_index = int'(csr_paddr) >> 2;
      if (reset) begin
         map_size_q = ogrf_pkg::MAP_SIZE_RESET;
         redraw_fence();
         pending_answers.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             reg_index == int'(ogrf_pkg::REG_MAP_SIZE)) begin
            if (csr_pwrite) begin
               map_size_q = csr_pwdata[ogrf_pkg::MAP_SIZE_BITS-1:0];
               redraw_fence();
            end else if (csr_prdata[ogrf_pkg::MAP_SIZE_BITS-1:0] !== map_size_q) begin
               report_mismatch($sformatf("map_size read %0d, want %0d",
                  csr_prdata[ogrf_pkg::MAP_SIZE_BITS-1:0], map_size_q));
            end
         end
         // a response beat always belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("response beat with no request pending");
            end else begin
               want = pending_answers.pop_front();
               if (rsp_occupied !== want.occupied)
                  report_mismatch($sformatf("occupied got %0b, want %0b",
                     rsp_occupied, want.occupied));
               if (rsp_done_res !== want.done_res)
                  report_mismatch($sformatf("done_res got %0b, want %0b",
                     rsp_done_res, want.done_res));
            end
         end
         if (req_valid && !req_stall)
            pending_answers.push_back(predict_cell_answer(ogrf_pkg::op_type'(req_op),
               int'(req_corner_a_x), int'(req_corner_a_y),
               int'(req_corner_b_x), int'(req_corner_b_y)));
      end
      answers_pending = pending_answers.size();
   end

endmodule

// File: dv/occupancy_grid_rect_fill_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy grid rectangle fill testbench
// directed corner cases at the reset map size, then random phases of adds,
// reads, clears and unused ops across small, saturated and full map sizes,
// with random gaps and stalls on both channels and two long response hold-offs
// ----------------------------------------------------------------------------
module occupancy_grid_rect_fill_test;

   localparam int REG_SPARE   = 1;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT = 200000;
   localparam int TAIL_CYCLES = 64;
   localparam int PHASE_ITEMS = 160;
   localparam int NUM_PHASES  = 10;
   localparam int LIMIT_NS    = 20_000_000;

   logic                                    clock;
   logic                                    reset;
   logic                                    req_valid;
   logic                                    req_stall;
   logic [1:0]                              req_op;
   logic signed [ogrf_pkg::COORD_BITS-1:0]  req_corner_a_x;
   logic signed [ogrf_pkg::COORD_BITS-1:0]  req_corner_a_y;
   logic signed [ogrf_pkg::COORD_BITS-1:0]  req_corner_b_x;
   logic signed [ogrf_pkg::COORD_BITS-1:0]  req_corner_b_y;
   logic                                    rsp_valid;
   logic                                    rsp_stall;
   logic                                    rsp_occupied;
   logic                                    rsp_done_res;
   logic                                    csr_psel;
   logic                                    csr_penable;
   logic                                    csr_pwrite;
   logic [ogrf_pkg::CSR_ADDR_BITS-1:0]      csr_paddr;
   logic [ogrf_pkg::CSR_DATA_BITS-1:0]      csr_pwdata;
   logic [ogrf_pkg::CSR_DATA_BITS-1:0]      csr_prdata;
   logic                                    csr_pready;

   int mismatch_count;
   int answers_pending;
   int grid_side_now;
   int last_x;
   int last_y;
   bit sender_quiet;
   bit receiver_quiet;

   // last entry is replaced by a random size at run time
   int phase_sizes [NUM_PHASES] = '{3, 0, 64, 2047, 17, 1, 65, 1024, 2, 0};

   occupancy_grid_rect_fill dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_corner_a_x (req_corner_a_x),
      .req_corner_a_y (req_corner_a_y),
      .req_corner_b_x (req_corner_b_x),
      .req_corner_b_y (req_corner_b_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_occupied   (rsp_occupied),
      .rsp_done_res   (rsp_done_res),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   occupancy_grid_rect_fill_checker grid_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_corner_a_x  (req_corner_a_x),
      .req_corner_a_y  (req_corner_a_y),
      .req_corner_b_x  (req_corner_b_x),
      .req_corner_b_y  (req_corner_b_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_occupied    (rsp_occupied),
      .rsp_done_res    (rsp_done_res),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [ogrf_pkg::COORD_BITS-1:0] coord_between(
      input int lo,
      input int hi
   );
      return ogrf_pkg::COORD_BITS'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   task automatic issue_command(
      input ogrf_pkg::op_type                       op,
      input logic signed [ogrf_pkg::COORD_BITS-1:0] ax,
      input logic signed [ogrf_pkg::COORD_BITS-1:0] ay,
      input logic signed [ogrf_pkg::COORD_BITS-1:0] bx,
      input logic signed [ogrf_pkg::COORD_BITS-1:0] by
   );
      int gap;
      if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
      gap = sender_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_corner_a_x <= ax;
      req_corner_a_y <= ay;
      req_corner_b_x <= bx;
      req_corner_b_y <= by;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic random_command();
      ogrf_pkg::op_type op;
      logic signed [ogrf_pkg::COORD_BITS-1:0] ax, ay, bx, by;
      int pick, mode;
      pick = $urandom_range(0, 255);
      ax = ogrf_pkg::COORD_BITS'($urandom());
      ay = ogrf_pkg::COORD_BITS'($urandom());
      bx = ogrf_pkg::COORD_BITS'($urandom());
      by = ogrf_pkg::COORD_BITS'($urandom());
      if (pick < 2) begin
         op = ogrf_pkg::OP_REINIT;
      end else if (pick < 6) begin
         op = ogrf_pkg::OP_NONE;
      end else if (pick < 124) begin
         op = ogrf_pkg::OP_ADD;
         mode = $urandom_range(0, 99);
         // mode 0 keeps the full-range corners
         if (mode != 0) begin
            ax = coord_between(-3, grid_side_now + 2);
            ay = coord_between(-3, grid_side_now + 2);
            if (mode < ((grid_side_now <= 128) ? 12 : 2)) begin
               bx = coord_between(-3, grid_side_now + 2);
               by = coord_between(-3, grid_side_now + 2);
            end else begin
               bx = ax + coord_between(-12, 12);
               by = ay + coord_between(-12, 12);
            end
            last_x = ax;
            last_y = ay;
         end
      end else begin
         op = ogrf_pkg::OP_READ;
         mode = $urandom_range(0, 7);
         if (mode < 4) begin
            ax = ogrf_pkg::COORD_BITS'(last_x + int'(coord_between(-3, 3)));
            ay = ogrf_pkg::COORD_BITS'(last_y + int'(coord_between(-3, 3)));
         end else if (mode < 7) begin
            ax = coord_between(-2, grid_side_now + 1);
            ay = coord_between(-2, grid_side_now + 1);
         end
      end
      issue_command(op, ax, ay, bx, by);
   endtask

   task automatic csr_access(
      input logic                               write,
      input int                                 index,
      input logic [ogrf_pkg::CSR_DATA_BITS-1:0] data
   );
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= ogrf_pkg::CSR_ADDR_BITS'(4 * index);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the checker count the last accepted beat before polling
      @(posedge clock);
      for (int n = 0; answers_pending != 0 && n < DRAIN_LIMIT; n++) @(posedge clock);
   endtask

   // response side: random stalls, quiet stretches and two long hold-offs
   initial begin
      int gap, taken;
      taken = 0;
      rsp_stall <= 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) receiver_quiet = !receiver_quiet;
         if (taken == 300 || taken == 1200) gap = HOLD_CYCLES;
         else gap = receiver_quiet ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      int size;
      logic [ogrf_pkg::CSR_DATA_BITS-1:0] csr_data;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= ogrf_pkg::OP_NONE;
      req_corner_a_x <= '0;
      req_corner_a_y <= '0;
      req_corner_b_x <= '0;
      req_corner_b_y <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      grid_side_now = int'(ogrf_pkg::MAP_SIZE_RESET);
      last_x = 0;
      last_y = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fence corners, interior, off-grid reads
      issue_command(ogrf_pkg::OP_READ, 0, 0, 0, 0);
      issue_command(ogrf_pkg::OP_READ, 999, 999, 0, 0);
      issue_command(ogrf_pkg::OP_READ, 500, 500, 0, 0);
      issue_command(ogrf_pkg::OP_READ, -1, 5, 0, 0);
      issue_command(ogrf_pkg::OP_READ, 1000, 5, 0, 0);
      issue_command(ogrf_pkg::OP_READ, 32767, -32768, 12345, -1);
      // plain and reversed rectangles
      issue_command(ogrf_pkg::OP_ADD, 10, 20, 12, 22);
      issue_command(ogrf_pkg::OP_READ, 11, 21, 0, 0);
      issue_command(ogrf_pkg::OP_ADD, 40, 50, 30, 45);
      issue_command(ogrf_pkg::OP_READ, 35, 47, 0, 0);
      // clamping at both ends of the coordinate range
      issue_command(ogrf_pkg::OP_ADD, -32768, 100, -5, 102);
      issue_command(ogrf_pkg::OP_ADD, 32767, 200, 995, 202);
      issue_command(ogrf_pkg::OP_READ, 999, 201, 0, 0);
      issue_command(ogrf_pkg::OP_READ, 997, 201, 0, 0);
      // single cell, then a span across a 64-cell word boundary
      issue_command(ogrf_pkg::OP_ADD, 300, 300, 300, 300);
      issue_command(ogrf_pkg::OP_READ, 300, 300, 0, 0);
      issue_command(ogrf_pkg::OP_READ, 301, 300, 0, 0);
      issue_command(ogrf_pkg::OP_ADD, 400, 60, 400, 70);
      issue_command(ogrf_pkg::OP_READ, 400, 63, 0, 0);
      issue_command(ogrf_pkg::OP_READ, 400, 64, 0, 0);
      issue_command(ogrf_pkg::OP_NONE, -1, 32767, -32768, 1);
      issue_command(ogrf_pkg::OP_REINIT, -1, -1, -1, -1);
      issue_command(ogrf_pkg::OP_READ, 11, 21, 0, 0);
      issue_command(ogrf_pkg::OP_ADD, -32768, -32768, 32767, 32767);
      issue_command(ogrf_pkg::OP_READ, 500, 500, 0, 0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         repeat (8) @(posedge clock);
         size = (p < NUM_PHASES - 1) ? phase_sizes[p] : $urandom_range(4, 150);
         if (p == 4) begin
            csr_access(1'b1, REG_SPARE, $urandom());
            csr_access(1'b0, int'(ogrf_pkg::REG_MAP_SIZE), '0);
         end
         csr_data = $urandom();
         csr_data[ogrf_pkg::MAP_SIZE_BITS-1:0] = ogrf_pkg::MAP_SIZE_BITS'(size);
         csr_access(1'b1, int'(ogrf_pkg::REG_MAP_SIZE), csr_data);
         csr_access(1'b0, int'(ogrf_pkg::REG_MAP_SIZE), '0);
         grid_side_now = (size < ogrf_pkg::SIDE_MIN) ? ogrf_pkg::SIDE_MIN :
                         (size > ogrf_pkg::GRID_SIDE_MAX) ? ogrf_pkg::GRID_SIDE_MAX : size;
         for (int i = 0; i < PHASE_ITEMS; i++) random_command();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && answers_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
